### hw/rtl/isc_pkg.sv
// Package with the command codes, walk states and cell token type of the interleaving check.
`timescale 1ns / 1ps

package isc_pkg;

    // Default capacity of the first and second string stores.
    localparam int unsigned MAX_LEN_DEF = 64;

    // Command codes carried in the slave-side tuser field.
    typedef enum logic [1:0] {
        CMD_FIRST  = 2'd0,
        CMD_SECOND = 2'd1,
        CMD_TARGET = 2'd2,
        CMD_EVAL   = 2'd3
    } t_cmd;

    // Control states of the evaluate sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } t_state;

    // Token handed from one cell to the next: one row of the match table.
    typedef struct packed {
        logic       vld;  // A row is present at this cell in this step.
        logic [7:0] a;    // First-string character of that row.
        logic       m;    // Match bit of the left neighbor for that row.
    } t_token;

endpackage

### hw/rtl/isc_head_cell.sv
// Column-zero cell of the match chain: starts each row and injects it into the chain.
`timescale 1ns / 1ps

module isc_head_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_run,
    input  logic [7:0]      i_a,
    input  logic [7:0]      i_tgt,
    output isc_pkg::t_token o_tok,
    output logic            o_match
);
    import isc_pkg::*;

    logic       r_m;
    logic       r_vld;
    logic [7:0] r_a;
    logic       n_m;

    // Column zero only matches while the first string runs along the target.
    assign n_m = r_m & (i_a == i_tgt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m   <= 1'b0;
            r_vld <= 1'b0;
        end else if (i_start) begin
            r_m   <= 1'b1;
            r_vld <= 1'b1;
        end else if (i_run) begin
            r_m   <= n_m;
            r_vld <= 1'b1;
        end else begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run) begin
            r_a <= i_a;
        end
    end

    assign o_tok   = '{vld: r_vld, a: r_a, m: r_m};
    assign o_match = r_m;

endmodule

### hw/rtl/isc_cell.sv
// One column cell of the match chain: holds a second-string character and its match bit.
`timescale 1ns / 1ps

module isc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_load,
    input  logic [7:0]      i_char,
    input  logic [7:0]      i_tgt,
    input  isc_pkg::t_token i_tok,
    output isc_pkg::t_token o_tok,
    output logic            o_match
);
    import isc_pkg::*;

    logic [7:0] r_s;
    logic       r_m;
    logic       r_vld;
    logic [7:0] r_a;
    logic       n_m;

    // Reach this entry either by taking the row's first-string character
    // from above, or by taking this column's second-string character.
    assign n_m = (r_m & (i_tok.a == i_tgt)) | (i_tok.m & (r_s == i_tgt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m   <= 1'b0;
            r_vld <= 1'b0;
        end else if (i_clear) begin
            r_m   <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_tok.vld;
            if (i_tok.vld) begin
                r_m <= n_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s <= i_char;
        end
        if (i_tok.vld) begin
            r_a <= i_tok.a;
        end
    end

    assign o_tok   = '{vld: r_vld, a: r_a, m: r_m};
    assign o_match = r_m;

endmodule

### hw/rtl/interleaving_string_check.sv
// Top level of the interleaving check: string stores, walk sequencer and the cell chain.
`timescale 1ns / 1ps

// Channel   Direction  Ports                       Contents
// slave     in         i_s_tvalid/o_s_tready       tuser: command, tdata: character byte
// master    out        o_m_tvalid/i_m_tready       tdata: answer, mismatch, overflow flags
//
// A load request is taken in the idle state, and the block stays ready for more requests.
// During an evaluate request the match table is walked as a diagonal wavefront along
// the cell chain, one step a cycle, until the last row reaches the cell of the final
// column. With a length mismatch, or when all three strings are empty, the table is
// not walked.
// Reset is synchronous and active low; it clears the lengths, the overflow flag,
// the cell match bits and the output register. Store contents are not cleared.
// Loads are taken while a finished result still waits; a stalled result holds
// the next evaluate in its result state until the master side takes it.

module interleaving_string_check #(
    parameter int unsigned MAX_LEN = isc_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_value
    input  logic [1:0] i_s_tuser,   // [1:0] command
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] is_interleaving, [1] length_mismatch,
                                    // [2] overflow, [7:3] zero
);
    import isc_pkg::*;

    // Length counters must hold the capacity itself; the target holds twice as much.
    localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
    localparam int unsigned TGT_W = $clog2(2 * MAX_LEN + 1);
    localparam int unsigned FA_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned TA_W  = $clog2(2 * MAX_LEN);

    // String stores. The second string lives in the cells of the chain.
    logic [7:0] first_mem  [MAX_LEN];
    logic [7:0] target_mem [2 * MAX_LEN];

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_first_len;
    logic [LEN_W-1:0] r_second_len;
    logic [TGT_W-1:0] r_target_len;
    logic             r_overflow;
    logic [TGT_W-1:0] r_step;
    logic             r_mismatch;
    logic [7:0]       r_rd_first;
    logic [7:0]       r_rd_target;
    logic             r_out_valid;
    logic [2:0]       r_out_flags;

    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_eval;
    logic             w_first_full;
    logic             w_second_full;
    logic             w_target_full;
    logic [TGT_W-1:0] w_sum;
    logic             w_len_mismatch;
    logic [TGT_W-1:0] w_addr;
    logic             w_head_run;
    logic             w_out_load;
    logic             w_answer;
    logic [MAX_LEN:0] w_match;
    t_token           w_tok [MAX_LEN+1];

    assign w_cmd          = t_cmd'(i_s_tuser);
    assign w_accept       = i_s_tvalid & o_s_tready;
    assign w_eval         = w_accept & (w_cmd == CMD_EVAL);
    assign w_first_full   = (r_first_len == LEN_W'(MAX_LEN));
    assign w_second_full  = (r_second_len == LEN_W'(MAX_LEN));
    assign w_target_full  = (r_target_len == TGT_W'(2 * MAX_LEN));
    assign w_sum          = TGT_W'(r_first_len) + TGT_W'(r_second_len);
    assign w_len_mismatch = (w_sum != r_target_len);

    // Next-state logic of the evaluate sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_eval) begin
                    if (w_len_mismatch || (w_sum == '0)) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_step == w_sum) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer. The head cell runs one row per step while
    // rows of the first string remain.
    always_comb begin
        o_s_tready = 1'b0;
        w_head_run = 1'b0;
        w_out_load = 1'b0;
        w_addr     = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_WALK: begin
                w_head_run = (r_step <= TGT_W'(r_first_len));
                w_addr     = r_step;
            end
            ST_RESULT: begin
                w_out_load = !r_out_valid || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lengths and overflow; cleared when the result of an evaluate is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_len  <= '0;
            r_second_len <= '0;
            r_target_len <= '0;
            r_overflow   <= 1'b0;
        end else if (w_out_load) begin
            r_first_len  <= '0;
            r_second_len <= '0;
            r_target_len <= '0;
            r_overflow   <= 1'b0;
        end else if (w_accept) begin
            case (w_cmd)
                CMD_FIRST: begin
                    if (w_first_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_first_len <= r_first_len + 1'b1;
                    end
                end
                CMD_SECOND: begin
                    if (w_second_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_second_len <= r_second_len + 1'b1;
                    end
                end
                CMD_TARGET: begin
                    if (w_target_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_target_len <= r_target_len + 1'b1;
                    end
                end
                default: begin
                    r_overflow <= r_overflow;
                end
            endcase
        end
    end

    // Step counter of the wavefront and the mismatch decision of the evaluate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_mismatch <= 1'b0;
        end else if (w_eval) begin
            r_step     <= TGT_W'(1);
            r_mismatch <= w_len_mismatch;
        end else if (r_state == ST_WALK) begin
            r_step <= r_step + 1'b1;
        end
    end

    // Store writes, and registered reads of the first and target stores at the step address.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_cmd == CMD_FIRST) && !w_first_full) begin
            first_mem[r_first_len[FA_W-1:0]] <= i_s_tdata;
        end
        if (w_accept && (w_cmd == CMD_TARGET) && !w_target_full) begin
            target_mem[r_target_len[TA_W-1:0]] <= i_s_tdata;
        end
        r_rd_first  <= first_mem[w_addr[FA_W-1:0]];
        r_rd_target <= target_mem[w_addr[TA_W-1:0]];
    end

    isc_head_cell u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_eval),
        .i_run   (w_head_run),
        .i_a     (r_rd_first),
        .i_tgt   (r_rd_target),
        .o_tok   (w_tok[0]),
        .o_match (w_match[0])
    );

    // Column j of the table is cell j; cell j processes row i at step i + j,
    // so every active cell compares against the same target character.
    for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
        isc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_eval),
            .i_load  (w_accept && (w_cmd == CMD_SECOND) &&
                      (r_second_len == LEN_W'(j - 1))),
            .i_char  (i_s_tdata),
            .i_tgt   (r_rd_target),
            .i_tok   (w_tok[j-1]),
            .o_tok   (w_tok[j]),
            .o_match (w_match[j])
        );
    end

    // The final column's bit answers the question once the last row has passed.
    assign w_answer = w_match[r_second_len];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_flags <= {r_overflow, r_mismatch, w_answer & ~r_mismatch};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_flags};

    // A mismatch never reports an interleaving.
    a_mismatch_false : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> !o_m_tdata[0])
        else $error("mismatch result reports an interleaving");

    // An evaluate request blocks further requests in the next cycle.
    a_eval_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == CMD_EVAL)) |=> !o_s_tready)
        else $error("request taken right after an evaluate");

    // The wavefront never steps past the final column of the last row.
    a_step_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_step <= w_sum))
        else $error("walk step beyond table size");

    // A new result appears only when the result state issues it.
    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_RESULT))
        else $error("result raised outside the result state");

endmodule

### tb/isc_verdict_checker.sv
// Checker that predicts and compares the verdicts of the interleaving check.
`timescale 1ns / 1ps

module isc_verdict_checker #(
    parameter int MAX_LEN = isc_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_value
    input  logic [1:0] i_s_tuser,   // [1:0] command
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [0] is_interleaving, [1] length_mismatch,
                                    // [2] overflow, [7:3] zero
    output int         o_pending,
    output int         o_fail_count
);

    import isc_pkg::*;

    // One verdict as it appears in the low bits of the master-side tdata.
    typedef struct packed {
        logic overflow;
        logic len_mismatch;
        logic match;
    } t_verdict;

    logic [7:0] first_mem  [MAX_LEN];
    logic [7:0] second_mem [MAX_LEN];
    logic [7:0] target_mem [2*MAX_LEN];
    int         first_len;
    int         second_len;
    int         target_len;
    logic       ovf_seen;
    t_verdict   verdict_q [$];

    // Rolling one-row walk over the match table of the current strings.
    function automatic logic walk_match_table();
        logic [MAX_LEN:0] row;
        logic [7:0]       a;
        logic [7:0]       t;
        logic             from_first;
        logic             from_second;
        row    = '0;
        row[0] = 1'b1;
        for (int j = 1; j <= second_len; j++)
            row[j] = row[j-1] && (second_mem[j-1] == target_mem[j-1]);
        for (int i = 1; i <= first_len; i++) begin
            a      = first_mem[i-1];
            row[0] = row[0] && (a == target_mem[i-1]);
            for (int j = 1; j <= second_len; j++) begin
                t           = target_mem[i+j-1];
                from_first  = row[j] && (a == t);
                from_second = row[j-1] && (second_mem[j-1] == t);
                row[j]      = from_first || from_second;
            end
        end
        return row[second_len];
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            first_len    = 0;
            second_len   = 0;
            target_len   = 0;
            ovf_seen     = 1'b0;
            verdict_q.delete();
            o_fail_count = 0;
        end else begin
            // Results first: a verdict can never leave in the cycle its request enters.
            if (i_m_tvalid && i_m_tready) begin
                got = t_verdict'(i_m_tdata[2:0]);
                if (verdict_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("unexpected result at %0t: tdata=%02h", $realtime, i_m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.match !== want.match || got.len_mismatch !== want.len_mismatch ||
                        got.overflow !== want.overflow) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display({"verdict mismatch at %0t: expected interleave=%0b ",
                                      "length_mismatch=%0b overflow=%0b, got %0b %0b %0b"},
                                     $realtime, want.match, want.len_mismatch, want.overflow,
                                     got.match, got.len_mismatch, got.overflow);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (t_cmd'(i_s_tuser))
                    CMD_FIRST: begin
                        if (first_len < MAX_LEN) begin
                            first_mem[first_len] = i_s_tdata;
                            first_len            = first_len + 1;
                        end else
                            ovf_seen = 1'b1;
                    end
                    CMD_SECOND: begin
                        if (second_len < MAX_LEN) begin
                            second_mem[second_len] = i_s_tdata;
                            second_len             = second_len + 1;
                        end else
                            ovf_seen = 1'b1;
                    end
                    CMD_TARGET: begin
                        if (target_len < 2*MAX_LEN) begin
                            target_mem[target_len] = i_s_tdata;
                            target_len             = target_len + 1;
                        end else
                            ovf_seen = 1'b1;
                    end
                    CMD_EVAL: begin
                        want.len_mismatch = (first_len + second_len) != target_len;
                        want.match        = want.len_mismatch ? 1'b0 : walk_match_table();
                        want.overflow     = ovf_seen;
                        verdict_q.push_back(want);
                        first_len  = 0;
                        second_len = 0;
                        target_len = 0;
                        ovf_seen   = 1'b0;
                    end
                    default: begin
                        ovf_seen = ovf_seen;
                    end
                endcase
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

### tb/testbench.sv
// Top of the interleaving check testbench: clock, reset, request and result drivers, verdict.
`timescale 1ns / 1ps

module testbench;

    import isc_pkg::*;

    localparam int MAX_LEN     = MAX_LEN_DEF;
    // Requests to send before the random part may stop, and the fewest evaluates it sends.
    localparam int ITEMS_GOAL  = 650;
    localparam int EVALS_GOAL  = 48;
    // Cycles without any handshake before the run is declared hung. The slowest correct
    // stretch is a long receiver hold-off plus one full-size walk, well under this.
    localparam int STALL_LIMIT = 5000;
    // Cycles left after the last result, more than the longest evaluate takes.
    localparam int TAIL_CYCLES = 200;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_CYCLES = 400;

    // Ways of breaking a merged target.
    typedef enum int {
        FAULT_NONE,
        FAULT_FLIP,
        FAULT_SWAP,
        FAULT_DROP,
        FAULT_APPEND
    } t_fault;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] char_value
    logic [1:0] s_tuser;    // [1:0] command
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [0] is_interleaving, [1] length_mismatch, [2] overflow

    int pending;
    int fail_count;
    int items_sent;
    int evals_sent;
    int src_idle_pct;
    int rx_stall_pct;
    int hold_ticket;
    int idle_cycles;

    interleaving_string_check #(
        .MAX_LEN    (MAX_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    isc_verdict_checker #(
        .MAX_LEN      (MAX_LEN)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The watchdog ends a run in which no request and no result moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side. Each falling edge decides tready for the next rising edge. When the
    // stimulus bumps hold_ticket, this process counts out a long hold-off on its own so
    // that results pile up and the block has to stall its request side.
    initial begin : result_sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offers one request and returns at the falling edge after it was taken. Random
    // idle cycles before the offer drop tvalid; once tvalid is up it stays up until
    // the handshake, as the stream protocol requires.
    task automatic send_request(input t_cmd cmd, input logic [7:0] ch);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent = items_sent + 1;
        if (cmd == CMD_EVAL)
            evals_sent = evals_sent + 1;
    endtask

    // Holds the request side quiet until every predicted verdict has been seen. It always
    // waits for a falling edge first, so the next request starts in a fresh step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Sets how often the sender idles and the receiver stalls for one stretch of cases.
    task automatic set_idle_phase(input int phase);
        case (phase)
            0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin src_idle_pct = 72; rx_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  rx_stall_pct = 72; end
            default: begin src_idle_pct = 38; rx_stall_pct = 38; end
        endcase
    endtask

    // One well-formed case: a first and second string of the given kept lengths, a target
    // merged from them at random, then an evaluate. The extra counts add characters past
    // the kept ones so that a full store drops them. A fault then breaks the target: it
    // flips a bit of one character, swaps two neighbors, drops the last character or
    // appends one, the last two giving a length mismatch. With a narrow alphabet only two
    // byte values occur, so many merges are possible and the walk goes deep.
    task automatic send_case(input int len_a, input int len_b, input int extra_a,
                             input int extra_b, input int extra_t, input t_fault fault,
                             input bit narrow);
        logic [7:0] str_a [$];
        logic [7:0] str_b [$];
        logic [7:0] str_t [$];
        logic [7:0] sym0;
        logic [7:0] sym1;
        logic [7:0] tmp;
        int         ia;
        int         ib;
        int         it;
        int         k;
        sym0 = 8'($urandom_range(255));
        sym1 = 8'($urandom_range(255));
        for (k = 0; k < len_a; k++)
            str_a.push_back(narrow ? ($urandom_range(1) ? sym1 : sym0) : 8'($urandom_range(255)));
        for (k = 0; k < len_b; k++)
            str_b.push_back(narrow ? ($urandom_range(1) ? sym1 : sym0) : 8'($urandom_range(255)));
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b) begin
            if (ib >= len_b || (ia < len_a && $urandom_range(1))) begin
                str_t.push_back(str_a[ia]);
                ia++;
            end else begin
                str_t.push_back(str_b[ib]);
                ib++;
            end
        end
        if (fault == FAULT_FLIP && str_t.size() > 0) begin
            k        = $urandom_range(str_t.size() - 1);
            str_t[k] = str_t[k] ^ (8'd1 << $urandom_range(7));
        end else if (fault == FAULT_SWAP && str_t.size() > 1) begin
            k          = $urandom_range(str_t.size() - 2);
            tmp        = str_t[k];
            str_t[k]   = str_t[k+1];
            str_t[k+1] = tmp;
        end else if (fault == FAULT_DROP && str_t.size() > 0)
            void'(str_t.pop_back());
        else if (fault == FAULT_APPEND)
            str_t.push_back(8'($urandom_range(255)));
        // Characters beyond the store capacity go after the kept ones of the same string.
        for (k = 0; k < extra_a; k++)
            str_a.push_back(8'($urandom_range(255)));
        for (k = 0; k < extra_b; k++)
            str_b.push_back(8'($urandom_range(255)));
        for (k = 0; k < extra_t; k++)
            str_t.push_back(8'($urandom_range(255)));
        // The three stores are independent, so their loads are mixed in random order.
        ia = 0;
        ib = 0;
        it = 0;
        while (ia < str_a.size() || ib < str_b.size() || it < str_t.size()) begin
            k = $urandom_range(2);
            if (k == 0 && ia < str_a.size()) begin
                send_request(CMD_FIRST, str_a[ia]);
                ia++;
            end else if (k == 1 && ib < str_b.size()) begin
                send_request(CMD_SECOND, str_b[ib]);
                ib++;
            end else if (k == 2 && it < str_t.size()) begin
                send_request(CMD_TARGET, str_t[it]);
                it++;
            end
        end
        send_request(CMD_EVAL, 8'($urandom_range(255)));
    endtask

    // A short burst of arbitrary requests, evaluates among them.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 10);
        repeat (n)
            send_request(t_cmd'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    initial begin : stimulus
        int  case_idx;
        int  r;
        int  len_a;
        int  len_b;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = CMD_FIRST;
        s_tdata      = 8'h00;
        items_sent   = 0;
        evals_sent   = 0;
        hold_ticket  = 0;
        src_idle_pct = 0;
        rx_stall_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run without idling.
        // Three empty strings form an interleaving.
        send_request(CMD_EVAL, 8'hFF);
        // Extreme byte values in both strings, merged second-first.
        send_request(CMD_FIRST, 8'h00);
        send_request(CMD_SECOND, 8'hFF);
        send_request(CMD_TARGET, 8'hFF);
        send_request(CMD_TARGET, 8'h00);
        send_request(CMD_EVAL, 8'h00);
        // Lengths agree but the character does not.
        send_request(CMD_FIRST, 8'hFF);
        send_request(CMD_TARGET, 8'h00);
        send_request(CMD_EVAL, 8'h00);
        // Target one longer than the two strings together.
        send_request(CMD_SECOND, 8'h55);
        send_request(CMD_TARGET, 8'h55);
        send_request(CMD_TARGET, 8'hAA);
        send_request(CMD_EVAL, 8'h00);
        // Equal characters in both strings, so the walk has to try either source.
        send_request(CMD_FIRST, 8'hAA);
        send_request(CMD_FIRST, 8'h55);
        send_request(CMD_SECOND, 8'hAA);
        send_request(CMD_TARGET, 8'hAA);
        send_request(CMD_TARGET, 8'hAA);
        send_request(CMD_TARGET, 8'h55);
        send_request(CMD_EVAL, 8'hFF);
        // A target alone against two empty strings.
        send_request(CMD_TARGET, 8'h01);
        send_request(CMD_EVAL, 8'h00);
        wait_drained();

        // Random part. The idle phases rotate every five cases.
        case_idx = 0;
        while (items_sent < ITEMS_GOAL || evals_sent < EVALS_GOAL) begin
            set_idle_phase((case_idx / 5) % 4);
            // Long receiver hold-off while the sender keeps offering requests.
            if (case_idx == 7)
                hold_ticket = hold_ticket + 1;
            // The sender pauses once until every verdict is out.
            if (case_idx == 20)
                wait_drained();
            if (case_idx == 3)
                // Full first store: 64 kept, two dropped, decided on the kept ones.
                send_case(MAX_LEN, 2, 2, 0, 0, FAULT_NONE, $urandom_range(1));
            else if (case_idx == 13)
                // Full second store with a single first character.
                send_case(1, MAX_LEN, 0, 1, 0, FAULT_NONE, $urandom_range(1));
            else if (case_idx == 26)
                // Full target store: one past its capacity, and a length mismatch.
                send_case(0, 0, 0, 0, 2*MAX_LEN + 1, FAULT_NONE, 1'b0);
            else begin
                r = $urandom_range(99);
                if (r < 15)
                    send_noise();
                else begin
                    len_a = ($urandom_range(9) == 0) ? $urandom_range(6, 16) : $urandom_range(4);
                    len_b = ($urandom_range(9) == 0) ? $urandom_range(6, 16) : $urandom_range(4);
                    send_case(len_a, len_b, 0, 0, 0,
                              (r < 40) ? t_fault'($urandom_range(1, 4)) : FAULT_NONE,
                              $urandom_range(1));
                end
            end
            case_idx++;
        end

        // Drain, then give the block time to show any result nobody asked for.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/isc_pkg.sv
hw/rtl/isc_head_cell.sv
hw/rtl/isc_cell.sv
hw/rtl/interleaving_string_check.sv
tb/isc_verdict_checker.sv
tb/testbench.sv
